// ----- src/hhlp_pkg.sv -----
// ----------------------------------------------------------------------------
// hhlp_pkg: HTTP header line parser package
// Shared types, byte codes, class and error codes for the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hhlp_pkg;

  localparam int unsigned MAX_OFF_W = 9;

  localparam logic [MAX_OFF_W-1:0] MAX_OFF_RESET = 9'd255;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [2:0] CLS_SKIP  = 3'd0;
  localparam logic [2:0] CLS_KEY   = 3'd1;
  localparam logic [2:0] CLS_SEP   = 3'd2;
  localparam logic [2:0] CLS_VALUE = 3'd3;
  localparam logic [2:0] CLS_TERM  = 3'd4;
  localparam logic [2:0] CLS_IDLE  = 3'd5;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_KEY_END  = 3'd1;
  localparam logic [2:0] ERR_NO_SPACE = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG = 3'd3;
  localparam logic [2:0] ERR_CR_NO_LF = 3'd4;

  typedef enum logic [8:0] {
    ST_START  = 9'b000000001,
    ST_KEY    = 9'b000000010,
    ST_COLON  = 9'b000000100,
    ST_SPACE  = 9'b000001000,
    ST_VALUE  = 9'b000010000,
    ST_CR     = 9'b000100000,
    ST_LF     = 9'b001000000,
    ST_END_CR = 9'b010000000,
    ST_DONE   = 9'b100000000
  } parse_state_t;

  typedef struct packed {
    parse_state_t         state;
    logic [MAX_OFF_W-1:0] value_offset;
    logic [2:0]           error_latched;
  } parse_ctx_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] byte_class;
    logic       pair_done;
    logic       header_done;
    logic [2:0] error_code;
  } parse_res_t;

endpackage

`default_nettype wire

// ----- src/hhlp_if.sv -----
// ----------------------------------------------------------------------------
// hhlp_if: header parser stream interfaces
// Valid/ready channels for raw header bytes in and tagged bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hhlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_request;

  modport source (output valid, output data_byte, output new_request, input ready);
  modport sink   (input valid, input data_byte, input new_request, output ready);
endinterface

interface hhlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [2:0] byte_class;
  logic       pair_done;
  logic       header_done;
  logic [2:0] error_code;

  modport source (output valid, output byte_out, output byte_class, output pair_done,
                  output header_done, output error_code, input ready);
  modport sink   (input valid, input byte_out, input byte_class, input pair_done,
                  input header_done, input error_code, output ready);
endinterface

`default_nettype wire

// ----- src/hhlp_step.sv -----
// ----------------------------------------------------------------------------
// hhlp_step: one-byte parser step
// Next parser context and the tagged result for one header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hhlp_step (
  input  hhlp_pkg::parse_ctx_t                  ctx,
  input  logic [7:0]                            data_byte,
  input  logic                                  new_request,
  input  logic [hhlp_pkg::MAX_OFF_W-1:0]        max_value_offset,
  output hhlp_pkg::parse_ctx_t                  ctx_nxt,
  output hhlp_pkg::parse_res_t                  res
);

  hhlp_pkg::parse_ctx_t                ctx_eff;
  logic [2:0]                          cls;
  logic                                pair;
  logic                                hdr;
  logic [2:0]                          err;
  logic [hhlp_pkg::MAX_OFF_W:0]        off_inc;

  always_comb begin
    // restart at line start before the byte is looked at
    if (new_request) begin
      ctx_eff.state         = hhlp_pkg::ST_START;
      ctx_eff.value_offset  = '0;
      ctx_eff.error_latched = hhlp_pkg::ERR_NONE;
    end else begin
      ctx_eff = ctx;
    end

    off_inc = {1'b0, ctx_eff.value_offset} + {{hhlp_pkg::MAX_OFF_W{1'b0}}, 1'b1};
    cls     = hhlp_pkg::CLS_IDLE;
    pair    = 1'b0;
    hdr     = 1'b0;
    err     = hhlp_pkg::ERR_NONE;
    ctx_nxt = ctx_eff;

    if (ctx_eff.error_latched == hhlp_pkg::ERR_NONE) begin
      case (ctx_eff.state)
        hhlp_pkg::ST_START: begin
          if (data_byte inside {hhlp_pkg::CH_CR, hhlp_pkg::CH_LF}) begin
            cls = hhlp_pkg::CLS_SKIP;
          end else begin
            cls           = hhlp_pkg::CLS_KEY;
            ctx_nxt.state = hhlp_pkg::ST_KEY;
          end
        end
        hhlp_pkg::ST_KEY: begin
          if (data_byte == hhlp_pkg::CH_COLON) begin
            cls           = hhlp_pkg::CLS_SEP;
            ctx_nxt.state = hhlp_pkg::ST_COLON;
          end else if (data_byte inside {hhlp_pkg::CH_CR, hhlp_pkg::CH_LF}) begin
            err = hhlp_pkg::ERR_KEY_END;
          end else begin
            cls = hhlp_pkg::CLS_KEY;
          end
        end
        hhlp_pkg::ST_COLON: begin
          if (data_byte == hhlp_pkg::CH_SPACE) begin
            cls           = hhlp_pkg::CLS_SEP;
            ctx_nxt.state = hhlp_pkg::ST_SPACE;
          end else begin
            err = hhlp_pkg::ERR_NO_SPACE;
          end
        end
        hhlp_pkg::ST_SPACE: begin
          // first value byte, whatever it holds
          cls                  = hhlp_pkg::CLS_VALUE;
          ctx_nxt.value_offset = '0;
          ctx_nxt.state        = hhlp_pkg::ST_VALUE;
        end
        hhlp_pkg::ST_VALUE: begin
          if (data_byte == hhlp_pkg::CH_CR) begin
            cls           = hhlp_pkg::CLS_TERM;
            ctx_nxt.state = hhlp_pkg::ST_CR;
          end else if (off_inc > {1'b0, max_value_offset}) begin
            err = hhlp_pkg::ERR_TOO_LONG;
          end else begin
            cls                  = hhlp_pkg::CLS_VALUE;
            ctx_nxt.value_offset = off_inc[hhlp_pkg::MAX_OFF_W-1:0];
          end
        end
        hhlp_pkg::ST_CR: begin
          if (data_byte == hhlp_pkg::CH_LF) begin
            cls           = hhlp_pkg::CLS_TERM;
            pair          = 1'b1;
            ctx_nxt.state = hhlp_pkg::ST_LF;
          end else begin
            err = hhlp_pkg::ERR_CR_NO_LF;
          end
        end
        hhlp_pkg::ST_LF: begin
          if (data_byte == hhlp_pkg::CH_CR) begin
            cls           = hhlp_pkg::CLS_TERM;
            ctx_nxt.state = hhlp_pkg::ST_END_CR;
          end else begin
            cls           = hhlp_pkg::CLS_KEY;
            ctx_nxt.state = hhlp_pkg::ST_KEY;
          end
        end
        hhlp_pkg::ST_END_CR: begin
          if (data_byte == hhlp_pkg::CH_LF) begin
            cls           = hhlp_pkg::CLS_TERM;
            hdr           = 1'b1;
            ctx_nxt.state = hhlp_pkg::ST_DONE;
          end else begin
            err = hhlp_pkg::ERR_CR_NO_LF;
          end
        end
        default: begin
          cls = hhlp_pkg::CLS_IDLE;
        end
      endcase

      if (err != hhlp_pkg::ERR_NONE) begin
        ctx_nxt.error_latched = err;
        cls                   = hhlp_pkg::CLS_IDLE;
      end
    end

    res.byte_out    = data_byte;
    res.byte_class  = cls;
    res.pair_done   = pair;
    res.header_done = hdr;
    res.error_code  = ctx_nxt.error_latched;
  end

endmodule

`default_nettype wire

// ----- src/http_header_line_parser.sv -----
// ----------------------------------------------------------------------------
// http_header_line_parser: HTTP header line parser
// Tags each header byte as key, separator, value, terminator, skip or idle
// and flags pair and header completion with sticky error reporting.
// ----------------------------------------------------------------------------
//  port     | dir | beat contents
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | data_byte, new_request
//  out_ch   | out | byte_out, byte_class, pair_done, header_done, error_code
//  cfg_*    | in  | max_value_offset write (9 bit), no read-back
//
//  One byte per clock sustained unless the output stalls; an input beat
//  passes the input register, then the parser step into the result register.
//  The parser context register closes the loop, one step per unstalled cycle.
//  A stalled output holds its beat; the input register takes one more beat.
//  Synchronous reset: empty pipeline, line start, limit 255.
// ----------------------------------------------------------------------------
`default_nettype none

module http_header_line_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  hhlp_in_if.sink                        in_ch,
  hhlp_out_if.source                     out_ch,
  input  logic                           cfg_wr_en,
  input  logic [hhlp_pkg::MAX_OFF_W-1:0] cfg_wr_data
);

  logic                           s1_valid_r;
  logic [7:0]                     s1_byte_r;
  logic                           s1_new_req_r;
  hhlp_pkg::parse_ctx_t           ctx_r;
  hhlp_pkg::parse_ctx_t           ctx_nxt;
  hhlp_pkg::parse_res_t           res_nxt;
  hhlp_pkg::parse_res_t           out_res_r;
  logic                           out_valid_r;
  logic [hhlp_pkg::MAX_OFF_W-1:0] max_off_r;
  logic                           s1_adv;
  logic                           in_rdy;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_rdy = !s1_valid_r || s1_adv;

  hhlp_step u_step (
    .ctx              (ctx_r),
    .data_byte        (s1_byte_r),
    .new_request      (s1_new_req_r),
    .max_value_offset (max_off_r),
    .ctx_nxt          (ctx_nxt),
    .res              (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      ctx_r.state         <= hhlp_pkg::ST_START;
      ctx_r.value_offset  <= '0;
      ctx_r.error_latched <= hhlp_pkg::ERR_NONE;
      max_off_r           <= hhlp_pkg::MAX_OFF_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_off_r <= cfg_wr_data;
      end
      if (in_rdy) begin
        s1_valid_r <= in_ch.valid;
      end
      // advance the context only when the result moves on
      if (s1_adv) begin
        ctx_r       <= ctx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      s1_byte_r    <= in_ch.data_byte;
      s1_new_req_r <= in_ch.new_request;
    end
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign in_ch.ready        = in_rdy;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.byte_out    = out_res_r.byte_out;
  assign out_ch.byte_class  = out_res_r.byte_class;
  assign out_ch.pair_done   = out_res_r.pair_done;
  assign out_ch.header_done = out_res_r.header_done;
  assign out_ch.error_code  = out_res_r.error_code;

endmodule

`default_nettype wire

// ----- src/hhlp_checker.sv -----
// ----------------------------------------------------------------------------
// hhlp_checker: header parser port checks
// Watches the result channel for consistent flags, codes and held beats.
// ----------------------------------------------------------------------------
`default_nettype none

module hhlp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] out_class,
  input wire logic       out_pair,
  input wire logic       out_hdr,
  input wire logic [2:0] out_err
);

  // an empty pipeline after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // hold a stalled beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_class)
      && $stable(out_err))
    else $error("stalled result beat changed");

  a_pair_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pair || out_hdr) |->
      out_class == hhlp_pkg::CLS_TERM && out_err == hhlp_pkg::ERR_NONE
      && !(out_pair && out_hdr))
    else $error("pair or header end flag on a non-terminator beat");

  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err != hhlp_pkg::ERR_NONE |-> out_class == hhlp_pkg::CLS_IDLE)
    else $error("errored beat not tagged idle");

endmodule

bind http_header_line_parser hhlp_checker u_hhlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.byte_out),
  .out_class (out_ch.byte_class),
  .out_pair  (out_ch.pair_done),
  .out_hdr   (out_ch.header_done),
  .out_err   (out_ch.error_code)
);

`default_nettype wire
